FILE: design/lapet_pkg.sv
// Shared types and constants for the Laplacian edge threshold block.
package lapet_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int FRAME_W     = 12;
  localparam int THRESH_W    = 8;
  localparam int WEIGHT_W    = 9;
  localparam int COLOR_W     = 8;
  localparam int GREY_W      = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    IDX_FRAME_WIDTH    = 3'd0,
    IDX_FRAME_HEIGHT   = 3'd1,
    IDX_EDGE_THRESHOLD = 3'd2,
    IDX_WEIGHT_RED     = 3'd3,
    IDX_WEIGHT_GREEN   = 3'd4,
    IDX_WEIGHT_BLUE    = 3'd5
  } cfg_index_t;

  localparam logic [FRAME_W-1:0]  RST_FRAME_WIDTH    = 12'd640;
  localparam logic [FRAME_W-1:0]  RST_FRAME_HEIGHT   = 12'd480;
  localparam logic [THRESH_W-1:0] RST_EDGE_THRESHOLD = 8'd128;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_RED     = 9'd77;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_GREEN   = 9'd150;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_BLUE    = 9'd29;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  typedef struct packed {
    logic               func;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic edge_res;
    logic frame_end;
  } out_item_t;

endpackage

FILE: design/laplacian_edge_threshold.sv
// Streaming 4-neighbor Laplacian edge detector with grey conversion and line stores.
//
// RGB pixels enter in raster order, one transaction per clock at most, and are turned into
// grey levels with programmable Q8 weights (saturated at 255). Two line stores keep the
// previous and the current grey row; the result of row r (one edge bit per pixel, set when
// 4c - up - down - left - right, clamped to 0..255, is above edge_threshold) comes out while
// row r+1 streams in. Neighbors outside the image are replaced by the center pixel. Row zero
// gives no results; once all rows are in, pixel transactions are dropped until flush
// transactions have emitted the last row, the final one carrying frame_end. Early flush
// transactions are dropped. Throughput is one transaction per cycle while in_ready is high:
// every input is handled by one combinational pass between the line-store read registers
// and the result register, and the line stores are read ahead at the position the next
// transaction will use. A two-entry output buffer keeps in_ready high while one result
// waits; in_ready drops only when both entries are full.
// The line stores are not cleared after reset and need no clearing pass. Write configuration
// only while the block is idle; a changed width or height takes effect on the next
// transaction, with position counters beyond the new limits held at the last column or row.
module laplacian_edge_threshold
  import lapet_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // Last column index for a programmed width: zero counts as one, large values saturate.
  function automatic logic [CW-1:0] last_col_of(input logic [FRAME_W-1:0] fw);
    logic [CW-1:0] lc;
    if (fw == '0) begin
      lc = '0;
    end else if (32'(fw) > MAX_WIDTH) begin
      lc = CW'(MAX_WIDTH - 1);
    end else begin
      lc = CW'(32'(fw) - 32'd1);
    end
    return lc;
  endfunction

  function automatic logic [HW-1:0] eff_height_of(input logic [FRAME_W-1:0] fh);
    logic [HW-1:0] h;
    if (fh == '0) begin
      h = HW'(1);
    end else if (32'(fh) > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(fh);
    end
    return h;
  endfunction

  function automatic logic [CW-1:0] min_col(input logic [CW-1:0] cnt, input logic [CW-1:0] lc);
    return (cnt > lc) ? lc : cnt;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Configuration registers; next values feed the read-ahead address logic
  // ---------------------------------------------------------------------------------------
  logic [FRAME_W-1:0]  frame_width_r,  frame_width_nxt;
  logic [FRAME_W-1:0]  frame_height_r, frame_height_nxt;
  logic [THRESH_W-1:0] threshold_r,    threshold_nxt;
  logic [WEIGHT_W-1:0] weight_red_r,   weight_red_nxt;
  logic [WEIGHT_W-1:0] weight_green_r, weight_green_nxt;
  logic [WEIGHT_W-1:0] weight_blue_r,  weight_blue_nxt;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    threshold_nxt    = threshold_r;
    weight_red_nxt   = weight_red_r;
    weight_green_nxt = weight_green_r;
    weight_blue_nxt  = weight_blue_r;
    if (cfg_we) begin
      case (cfg_index)
        IDX_FRAME_WIDTH:    frame_width_nxt  = cfg_wdata[FRAME_W-1:0];
        IDX_FRAME_HEIGHT:   frame_height_nxt = cfg_wdata[FRAME_W-1:0];
        IDX_EDGE_THRESHOLD: threshold_nxt    = cfg_wdata[THRESH_W-1:0];
        IDX_WEIGHT_RED:     weight_red_nxt   = cfg_wdata[WEIGHT_W-1:0];
        IDX_WEIGHT_GREEN:   weight_green_nxt = cfg_wdata[WEIGHT_W-1:0];
        IDX_WEIGHT_BLUE:    weight_blue_nxt  = cfg_wdata[WEIGHT_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      threshold_r    <= RST_EDGE_THRESHOLD;
      weight_red_r   <= RST_WEIGHT_RED;
      weight_green_r <= RST_WEIGHT_GREEN;
      weight_blue_r  <= RST_WEIGHT_BLUE;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      threshold_r    <= threshold_nxt;
      weight_red_r   <= weight_red_nxt;
      weight_green_r <= weight_green_nxt;
      weight_blue_r  <= weight_blue_nxt;
    end
  end

  logic [CW-1:0] last_col, last_col_nxt;
  logic [HW-1:0] height, height_nxt;

  assign last_col     = last_col_of(frame_width_r);
  assign height       = eff_height_of(frame_height_r);
  assign last_col_nxt = last_col_of(frame_width_nxt);
  assign height_nxt   = eff_height_of(frame_height_nxt);

  // ---------------------------------------------------------------------------------------
  // Position state
  // ---------------------------------------------------------------------------------------
  logic [CW-1:0]      col_r,   col_nxt;
  logic [HW-1:0]      row_r,   row_nxt;
  logic [CW-1:0]      flush_r, flush_nxt;
  logic [GREY_W-1:0]  left_r,  left_nxt;

  // Line stores. newer_b duplicates newer_a so the flush path can see the left neighbor.
  logic [GREY_W-1:0] newer_a [MAX_WIDTH];
  logic [GREY_W-1:0] newer_b [MAX_WIDTH];
  logic [GREY_W-1:0] older   [MAX_WIDTH];

  logic [GREY_W-1:0] rd_center_r;  // newer[c]
  logic [GREY_W-1:0] rd_right_r;   // newer[c+1]
  logic [GREY_W-1:0] rd_left_r;    // newer[c-1]
  logic [GREY_W-1:0] rd_up_r;      // older[c]

  // Output buffer
  logic      out_valid_r, skid_valid_r;
  out_item_t out_data_r,  skid_data_r;

  logic in_fire;
  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;

  // ---------------------------------------------------------------------------------------
  // Grey conversion of the incoming pixel
  // ---------------------------------------------------------------------------------------
  localparam int SUM_W = WEIGHT_W + COLOR_W + 2;

  logic [SUM_W-1:0]  grey_sum;
  logic [GREY_W-1:0] grey;

  assign grey_sum = SUM_W'(weight_red_r * in_data.red)
                  + SUM_W'(weight_green_r * in_data.green)
                  + SUM_W'(weight_blue_r * in_data.blue);
  assign grey = (grey_sum[SUM_W-1:8] > (SUM_W-8)'(255)) ? GREY_W'(255) : grey_sum[15:8];

  // ---------------------------------------------------------------------------------------
  // Neighborhood selection and Laplacian
  // ---------------------------------------------------------------------------------------
  logic              is_flush;
  logic              acc_pix, acc_flush;
  logic [CW-1:0]     c_pix, c_flush, c_cur;
  logic              at_last;
  logic [GREY_W-1:0] n_up, n_down, n_left, n_right;
  logic signed [11:0] lap;
  logic [GREY_W-1:0] lap_clamped;
  logic              produce;
  out_item_t         result;

  assign is_flush  = (in_data.func == FUNC_FLUSH);
  assign acc_pix   = in_fire && !is_flush && (row_r < height);
  assign acc_flush = in_fire && is_flush && (row_r >= height);
  assign c_pix     = min_col(col_r, last_col);
  assign c_flush   = min_col(flush_r, last_col);
  assign c_cur     = is_flush ? c_flush : c_pix;
  assign at_last   = (c_cur >= last_col);

  always_comb begin
    n_right = at_last ? rd_center_r : rd_right_r;
    if (is_flush) begin
      n_up   = (height == HW'(1)) ? rd_center_r : rd_up_r;
      n_down = rd_center_r;
      n_left = (c_cur == '0) ? rd_center_r : rd_left_r;
    end else begin
      n_up   = (row_r == HW'(1)) ? rd_center_r : rd_up_r;
      n_down = grey;
      n_left = (c_cur == '0) ? rd_center_r : left_r;
    end
  end

  assign lap = $signed({2'b00, rd_center_r, 2'b00})
             - $signed({4'b0000, n_up})
             - $signed({4'b0000, n_down})
             - $signed({4'b0000, n_left})
             - $signed({4'b0000, n_right});

  always_comb begin
    if (lap < 0) begin
      lap_clamped = '0;
    end else if (lap > 12'sd255) begin
      lap_clamped = GREY_W'(255);
    end else begin
      lap_clamped = lap[GREY_W-1:0];
    end
  end

  assign produce         = acc_flush || (acc_pix && (row_r != '0));
  assign result.edge_res  = (lap_clamped > threshold_r);
  assign result.frame_end = acc_flush && at_last;

  // ---------------------------------------------------------------------------------------
  // Counter update
  // ---------------------------------------------------------------------------------------
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    flush_nxt = flush_r;
    left_nxt  = left_r;
    if (acc_pix) begin
      if (row_r != '0) begin
        left_nxt = rd_center_r;
      end
      if (at_last) begin
        col_nxt = '0;
        row_nxt = row_r + HW'(1);
      end else begin
        col_nxt = c_pix + CW'(1);
      end
    end else if (acc_flush) begin
      if (at_last) begin
        // Close the image and start over with the next pixel.
        col_nxt   = '0;
        row_nxt   = '0;
        flush_nxt = '0;
        left_nxt  = '0;
      end else begin
        flush_nxt = c_flush + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      flush_r <= '0;
      left_r  <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      flush_r <= flush_nxt;
      left_r  <= left_nxt;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Line stores: write the current column, read ahead at the column the next transaction
  // will use. A read that hits the column being written takes the new value.
  // ---------------------------------------------------------------------------------------
  logic [CW-1:0] rd_addr, rd_addr_p1, rd_addr_m1;

  assign rd_addr    = (row_nxt >= height_nxt) ? min_col(flush_nxt, last_col_nxt)
                                              : min_col(col_nxt, last_col_nxt);
  assign rd_addr_p1 = rd_addr + CW'(1);
  assign rd_addr_m1 = rd_addr - CW'(1);

  logic older_we;
  assign older_we = acc_pix && (row_r != '0);

  always_ff @(posedge clk) begin
    if (acc_pix) begin
      newer_a[c_pix] <= grey;
      newer_b[c_pix] <= grey;
    end
    if (older_we) begin
      older[c_pix] <= rd_center_r;
    end
    rd_center_r <= (acc_pix && (c_pix == rd_addr))    ? grey : newer_a[rd_addr];
    rd_right_r  <= (acc_pix && (c_pix == rd_addr_p1)) ? grey : newer_a[rd_addr_p1];
    rd_left_r   <= (acc_pix && (c_pix == rd_addr_m1)) ? grey : newer_b[rd_addr_m1];
    rd_up_r     <= (older_we && (c_pix == rd_addr))   ? rd_center_r : older[rd_addr];
  end

  // ---------------------------------------------------------------------------------------
  // Two-entry output buffer: the skid entry catches a result while the head is stalled.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_ready) begin
      // Hold the head; park a new result in the skid entry.
      if (produce) begin
        skid_valid_r <= 1'b1;
        skid_data_r  <= result;
      end
    end else if (skid_valid_r) begin
      // Advance the skid entry to the head.
      out_valid_r  <= 1'b1;
      out_data_r   <= skid_data_r;
      skid_valid_r <= produce;
      if (produce) begin
        skid_data_r <= result;
      end
    end else begin
      out_valid_r <= produce;
      if (produce) begin
        out_data_r <= result;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: test/edge_checker.sv
// Checker for the Laplacian edge block: mirrors its state, predicts edge bits, compares them.
module edge_checker
  import lapet_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  in_item_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  out_item_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Mirrored registers.
  logic [FRAME_W-1:0]  width_reg;
  logic [FRAME_W-1:0]  height_reg;
  logic [THRESH_W-1:0] thresh_reg;
  logic [WEIGHT_W-1:0] wt_red, wt_green, wt_blue;

  // Grey line stores and raster position.
  bit [GREY_W-1:0] older_q [MAX_WIDTH];
  bit [GREY_W-1:0] newer_q [MAX_WIDTH];
  int unsigned     col_pos, row_pos, flush_pos;
  logic [GREY_W-1:0] left_grey;

  out_item_t edge_bits_due [$];
  int        mismatches = 0;

  // Clamp 4c - neighbors to 0..255 and compare against the threshold.
  function automatic logic laplace_hot(input logic [7:0] ctr, up, dn, lf, rt);
    int lap;
    lap = 4 * int'(ctr) - int'(up) - int'(dn) - int'(lf) - int'(rt);
    if (lap < 0) lap = 0;
    if (lap > 255) lap = 255;
    return lap > int'(thresh_reg);
  endfunction

  task automatic predict_edges(input in_item_t item);
    int unsigned w, h, last, c, sum;
    logic [GREY_W-1:0] g, ctr, up, lf, rt;
    out_item_t res;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
    last = w - 1;
    if (item.func == FUNC_PIXEL) begin
      if (row_pos >= h) return;
      if (col_pos > last) col_pos = last;
      c = col_pos;
      sum = (int'(wt_red) * int'(item.red) + int'(wt_green) * int'(item.green)
             + int'(wt_blue) * int'(item.blue)) >> 8;
      g = (sum > 255) ? 8'hFF : sum[7:0];
      // Row r resolves once the pixel below it arrives.
      if (row_pos >= 1) begin
        ctr = newer_q[c];
        up  = (row_pos == 1) ? ctr : older_q[c];
        lf  = (c == 0) ? ctr : left_grey;
        rt  = (c >= last) ? ctr : newer_q[c + 1];
        res.edge_res  = laplace_hot(ctr, up, g, lf, rt);
        res.frame_end = 1'b0;
        edge_bits_due.push_back(res);
        left_grey  = ctr;
        older_q[c] = ctr;
      end
      newer_q[c] = g;
      if (c >= last) begin
        col_pos = 0;
        row_pos++;
      end else begin
        col_pos = c + 1;
      end
    end else begin
      if (row_pos < h) return;
      if (flush_pos > last) flush_pos = last;
      c   = flush_pos;
      ctr = newer_q[c];
      up  = (h == 1) ? ctr : older_q[c];
      lf  = (c == 0) ? ctr : newer_q[c - 1];
      rt  = (c >= last) ? ctr : newer_q[c + 1];
      res.edge_res = laplace_hot(ctr, up, ctr, lf, rt);
      if (c >= last) begin
        res.frame_end = 1'b1;
        flush_pos = 0;
        row_pos   = 0;
        col_pos   = 0;
        left_grey = '0;
      end else begin
        res.frame_end = 1'b0;
        flush_pos = c + 1;
      end
      edge_bits_due.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      width_reg  = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      thresh_reg = RST_EDGE_THRESHOLD;
      wt_red     = RST_WEIGHT_RED;
      wt_green   = RST_WEIGHT_GREEN;
      wt_blue    = RST_WEIGHT_BLUE;
      col_pos    = 0;
      row_pos    = 0;
      flush_pos  = 0;
      left_grey  = '0;
      edge_bits_due.delete();
    end else begin
      // Results first: a result never belongs to a transaction accepted at the same edge.
      if (out_valid && out_ready) begin
        if (edge_bits_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected: edge_res %0b frame_end %0b",
                   $time, out_data.edge_res, out_data.frame_end);
        end else begin
          want = edge_bits_due.pop_front();
          if (out_data.edge_res !== want.edge_res) begin
            mismatches++;
            $display("%0t: edge_res expected %0b actual %0b",
                     $time, want.edge_res, out_data.edge_res);
          end
          if (out_data.frame_end !== want.frame_end) begin
            mismatches++;
            $display("%0t: frame_end expected %0b actual %0b",
                     $time, want.frame_end, out_data.frame_end);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          IDX_FRAME_WIDTH:    width_reg  = cfg_wdata[FRAME_W-1:0];
          IDX_FRAME_HEIGHT:   height_reg = cfg_wdata[FRAME_W-1:0];
          IDX_EDGE_THRESHOLD: thresh_reg = cfg_wdata[THRESH_W-1:0];
          IDX_WEIGHT_RED:     wt_red     = cfg_wdata[WEIGHT_W-1:0];
          IDX_WEIGHT_GREEN:   wt_green   = cfg_wdata[WEIGHT_W-1:0];
          IDX_WEIGHT_BLUE:    wt_blue    = cfg_wdata[WEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_edges(in_data);
    end
    pending    <= edge_bits_due.size();
    fail_count <= mismatches;
  end

endmodule

FILE: test/testbench.sv
// Top level of the edge detector testbench: clock, reset, stimulus, idling and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lapet_pkg::*;

  localparam int          FRAME_MAX   = 2048;
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned HOLD_CYCLES = 300;
  // Index past the last register; the block must ignore writes to it.
  localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX = 3'd6;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;
  int unsigned frame_items = 0;
  bit          calm = 1'b0;      // no idling on either side while set
  bit          hold_req = 1'b0;  // ask the receiver for one long hold-off

  always #10 clk = ~clk;

  laplacian_edge_threshold u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  edge_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: stall about a quarter of the cycles, except while calm. Once asked,
  // hold off for a long stretch so the output buffer fills and in_ready drops.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= 25);
    end
  end

  // Offer one transaction and return at the edge that accepts it. Valid stays high
  // afterwards so back-to-back transactions need no extra edge.
  task automatic offer(input logic func, input logic [COLOR_W-1:0] r, g, b);
    while (!calm && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{func: func, red: r, green: g, blue: b};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Write every register; unused upper data bits get random junk the block must drop.
  task automatic configure(input logic [FRAME_W-1:0] w, h, input logic [THRESH_W-1:0] thr,
                           input logic [WEIGHT_W-1:0] wr, wg, wb);
    write_reg(IDX_FRAME_WIDTH, w);
    write_reg(IDX_FRAME_HEIGHT, h);
    write_reg(IDX_EDGE_THRESHOLD, {4'($urandom), thr});
    write_reg(IDX_WEIGHT_RED, {3'($urandom), wr});
    write_reg(IDX_WEIGHT_GREEN, {3'($urandom), wg});
    write_reg(IDX_WEIGHT_BLUE, {3'($urandom), wb});
    cfg_we <= 1'b0;
  endtask

  // Drop valid, wait for every expected result, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Pixel component: plain random, hard black/white, or a gentle ramp near mid grey.
  function automatic logic [COLOR_W-1:0] tone(input int unsigned style);
    case (style)
      0:       return 8'($urandom);
      1:       return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return 8'(8'd120 + $urandom_range(15));
    endcase
  endfunction

  function automatic logic [THRESH_W-1:0] pick_threshold();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(4))
      0:       return 9'd0;
      1:       return 9'd256;
      2:       return 9'd511;
      default: return 9'($urandom_range(511));
    endcase
  endfunction

  // One whole image plus its flush row. A noisy image also carries early flushes,
  // which the block must drop, and stray pixels after the last row.
  task automatic send_frame(input int unsigned w, h, style, input bit noisy);
    for (int unsigned p = 0; p < w * h; p++) begin
      if (noisy && $urandom_range(19) == 0)
        offer(FUNC_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
      offer(FUNC_PIXEL, tone(style), tone(style), tone(style));
    end
    if (noisy) begin
      repeat ($urandom_range(3)) offer(FUNC_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    end
    for (int unsigned c = 0; c < w; c++)
      offer(FUNC_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    int unsigned       w, h, frames, phase;
    logic [FRAME_W-1:0] wcfg, hcfg;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a write to a missing register must change nothing.
    write_reg(SPARE_INDEX, '1);

    // 3x2 image, full weights so grey saturates, threshold zero.
    configure(12'd3, 12'd2, 8'd0, 9'd256, 9'd256, 9'd256);
    offer(FUNC_FLUSH, 8'hFF, 8'hFF, 8'hFF);          // early flush: dropped
    offer(FUNC_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    offer(FUNC_PIXEL, 8'h00, 8'h00, 8'h00);
    offer(FUNC_PIXEL, 8'hFF, 8'h00, 8'h00);
    offer(FUNC_PIXEL, 8'h00, 8'h00, 8'h00);
    offer(FUNC_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    offer(FUNC_PIXEL, 8'h00, 8'hFF, 8'h00);
    offer(FUNC_PIXEL, 8'h80, 8'h80, 8'h80);          // past the last row: dropped
    repeat (3) offer(FUNC_FLUSH, 8'h00, 8'h00, 8'h00);
    drain();

    // Zero width and height read as one; weights above 256 are used as written.
    configure(12'd0, 12'd0, 8'hFF, 9'd511, 9'd511, 9'd511);
    offer(FUNC_PIXEL, 8'hFF, 8'h00, 8'h7F);
    offer(FUNC_FLUSH, 8'h00, 8'h00, 8'h00);
    drain();

    // Shrink the width in the middle of a row, then the height after the rows are in:
    // the position counters must hold at the new last column and row.
    configure(12'd5, 12'd4, 8'd40, RST_WEIGHT_RED, RST_WEIGHT_GREEN, RST_WEIGHT_BLUE);
    repeat (8) offer(FUNC_PIXEL, tone(1), tone(1), tone(1));
    drain();
    configure(12'd2, 12'd4, 8'd40, RST_WEIGHT_RED, RST_WEIGHT_GREEN, RST_WEIGHT_BLUE);
    repeat (3) offer(FUNC_PIXEL, tone(1), tone(1), tone(1));
    drain();
    configure(12'd2, 12'd2, 8'd40, RST_WEIGHT_RED, RST_WEIGHT_GREEN, RST_WEIGHT_BLUE);
    repeat (2) offer(FUNC_FLUSH, 8'h00, 8'h00, 8'h00);
    drain();

    // Random phases of small images; phase four is a fixed 8x6 image streamed while
    // the receiver holds off, and a calm stretch follows in the middle.
    for (phase = 0; frame_items < 800; phase++) begin
      calm = (phase >= 6 && phase < 10);
      case (phase)
        4:       begin wcfg = 12'd8;    hcfg = 12'd6;   end
        default: begin
          wcfg = 12'($urandom_range(1, 8));
          hcfg = 12'($urandom_range(1, 6));
        end
      endcase
      configure(wcfg, hcfg, pick_threshold(), pick_weight(), pick_weight(), pick_weight());
      // Stall the receiver while this phase streams so the block backs up.
      if (phase == 4) hold_req = 1'b1;
      w = (wcfg == 0) ? 1 : ((wcfg > FRAME_MAX) ? FRAME_MAX : wcfg);
      h = (hcfg == 0) ? 1 : ((hcfg > FRAME_MAX) ? FRAME_MAX : hcfg);
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        send_frame(w, h, $urandom_range(2), $urandom_range(3) == 0);
        frame_items += w * h + w;
      end
      drain();
    end

    repeat (16) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
